FILE: src/mmt_pkg.sv
// Package: constants, command codes and controller/datapath interface types.
`default_nettype none
package mmt_pkg;
	localparam int CHANNELS = 4;
	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int STATE_WORDS = 624;
	localparam int TWIST_OFFSET = 397;
	localparam int IDX_W = 10;
	localparam int ADDR_W = $clog2(CHANNELS * STATE_WORDS);
	localparam logic [31:0] TWIST_MATRIX = 32'h9908b0df;
	localparam logic [31:0] HIGH_BIT = 32'h80000000;
	localparam logic [31:0] LOW_BITS = 32'h7fffffff;
	localparam logic [31:0] INIT_MULT = 32'd1812433253;
	localparam logic [31:0] DEFAULT_SEED = 32'd5489;
	localparam logic [31:0] TEMPER_B = 32'h9d2c5680;
	localparam logic [31:0] TEMPER_C = 32'hefc60000;
	localparam logic [IDX_W-1:0] POS_FULL = IDX_W'(STATE_WORDS);
	localparam logic [IDX_W-1:0] POS_UNSEEDED = IDX_W'(STATE_WORDS + 1);

	typedef enum logic [1:0] {
		CMD_SEED = 2'd0,
		CMD_INT  = 2'd1,
		CMD_FRAC = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		DP_IDLE    = 4'd0,
		DP_LOAD    = 4'd1,   // take channel/seed/command into datapath
		DP_SEED0   = 4'd2,   // write word 0 with seed
		DP_SEEDN   = 4'd3,   // compute/write next init word
		DP_TW_RD   = 4'd4,   // issue twist reads
		DP_TW_RD2  = 4'd5,
		DP_TW_WR   = 4'd6,   // write twisted word
		DP_DRAW_RD = 4'd7,
		DP_DRAW_WR = 4'd8,   // temper and collect word
		DP_EMIT    = 4'd9
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   use_default;
	} dp_cmd_t;

	typedef struct packed {
		logic seed_last;     // init recurrence is on last word
		logic twist_last;    // twist is on last word
		logic need_seed;     // channel position is unseeded
		logic need_twist;    // channel position past end
		logic second_word;   // fraction has one word already
		logic is_frac;
		logic is_seed;
		logic is_none;
	} dp_status_t;
endpackage
`default_nettype wire

FILE: src/multichannel_mersenne_twister_unit.sv
// Top level: bank of MT19937 generators, controller plus datapath.
// A draw past the state end first twists all state words; an unseeded draw first
// runs the init recurrence with the default seed.
// One transaction at a time: a new one is accepted only in idle, after the last is done.
// Reset: positions mark all channels unseeded; state memory is not cleared.
`default_nettype none
module multichannel_mersenne_twister_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  command,
	input  wire logic [1:0]  channel,
	input  wire logic [31:0] seed_value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [52:0]      random_value
);
	import mmt_pkg::*;

	dp_cmd_t cmd;
	dp_status_t status;

	mmt_controller u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .status(status), .cmd(cmd)
	);

	mmt_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .in_command(command), .in_channel(channel),
		.in_seed(seed_value), .cmd(cmd), .status(status), .result(random_value)
	);
endmodule
`default_nettype wire

FILE: src/mmt_datapath.sv
// Datapath: state memory, per-channel positions, init, twist and temper logic.
`default_nettype none
module mmt_datapath (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [1:0]             in_command,
	input  wire logic [1:0]             in_channel,
	input  wire logic [31:0]            in_seed,
	input  wire mmt_pkg::dp_cmd_t       cmd,
	output mmt_pkg::dp_status_t         status,
	output logic [52:0]                 result
);
	import mmt_pkg::*;

	logic [31:0] mem [CHANNELS*STATE_WORDS];
	logic [31:0] rdata_q;
	logic [ADDR_W-1:0] raddr, waddr;
	logic [31:0] wdata;
	logic we;

	logic [IDX_W-1:0] pos_q [CHANNELS];
	logic [CH_W-1:0] ch_q;
	cmd_t cmd_q;
	logic [31:0] seed_q, prev_q, cur_q, mult_q;
	logic [IDX_W-1:0] k_q;
	logic [1:0] ph_q;
	logic have1_q;
	logic [26:0] a_q;
	logic [52:0] res_q;

	function automatic logic [IDX_W-1:0] wrap(input logic [IDX_W:0] v);
		return (v >= (IDX_W+1)'(STATE_WORDS)) ? IDX_W'(v - (IDX_W+1)'(STATE_WORDS))
			: IDX_W'(v);
	endfunction

	function automatic logic [ADDR_W-1:0] addr(input logic [CH_W-1:0] c,
			input logic [IDX_W-1:0] i);
		return ADDR_W'(c) * ADDR_W'(STATE_WORDS) + ADDR_W'(i);
	endfunction

	logic [CH_W-1:0] ch_in;
	assign ch_in = CH_W'(32'(in_channel) % CHANNELS);

	logic [31:0] y, t;
	always_comb begin
		y = rdata_q;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		t = y ^ (y >> 18);
	end

	logic [31:0] tw_y;
	assign tw_y = (cur_q & HIGH_BIT) | (prev_q & LOW_BITS);

	always_comb begin
		raddr = addr(ch_q, k_q);
		waddr = addr(ch_q, k_q);
		wdata = mult_q + 32'(k_q);
		we = 1'b0;
		unique case (cmd.op)
			DP_SEED0: begin
				we = 1'b1;
				wdata = cmd.use_default ? DEFAULT_SEED : seed_q;
			end
			DP_SEEDN: we = (ph_q == 2'd1);
			DP_TW_RD: raddr = addr(ch_q, (ph_q == 2'd0) ? k_q
				: wrap((IDX_W+1)'(k_q) + (IDX_W+1)'(1)));
			DP_TW_RD2: raddr = addr(ch_q, wrap((IDX_W+1)'(k_q)
				+ (IDX_W+1)'(TWIST_OFFSET)));
			DP_TW_WR: begin
				we = 1'b1;
				wdata = rdata_q ^ (tw_y >> 1) ^ (tw_y[0] ? TWIST_MATRIX : 32'd0);
			end
			DP_DRAW_RD: raddr = addr(ch_q, pos_q[ch_q]);
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) pos_q[c] <= POS_UNSEEDED;
			ph_q <= '0;
			k_q <= '0;
			have1_q <= 1'b0;
			ch_q <= '0;
			cmd_q <= CMD_NONE;
			seed_q <= '0;
			prev_q <= '0;
			cur_q <= '0;
			mult_q <= '0;
			a_q <= '0;
			res_q <= '0;
		end else begin
			unique case (cmd.op)
				DP_LOAD: begin
					ch_q <= ch_in;
					cmd_q <= cmd_t'(in_command);
					seed_q <= in_seed;
					have1_q <= 1'b0;
					ph_q <= '0;
				end
				DP_SEED0: begin
					prev_q <= wdata;
					k_q <= IDX_W'(1);
					ph_q <= '0;
				end
				DP_SEEDN: begin
					if (ph_q == 2'd0) begin
						mult_q <= INIT_MULT * (prev_q ^ (prev_q >> 30));
						ph_q <= 2'd1;
					end else begin
						prev_q <= wdata;
						k_q <= k_q + IDX_W'(1);
						ph_q <= '0;
						if (k_q == IDX_W'(STATE_WORDS-1)) begin
							pos_q[ch_q] <= POS_FULL;
							k_q <= '0;
						end
					end
				end
				DP_TW_RD: begin
					// rdata of word k lands next cycle; capture on second pass
					if (ph_q == 2'd1) cur_q <= rdata_q;
					ph_q <= ph_q + 2'd1;
				end
				DP_TW_RD2: prev_q <= rdata_q;
				DP_TW_WR: begin
					ph_q <= '0;
					k_q <= k_q + IDX_W'(1);
					if (k_q == IDX_W'(STATE_WORDS-1)) begin
						pos_q[ch_q] <= '0;
						k_q <= '0;
					end
				end
				DP_DRAW_RD: ph_q <= '0;
				DP_DRAW_WR: begin
					pos_q[ch_q] <= pos_q[ch_q] + IDX_W'(1);
					if (cmd_q == CMD_INT) res_q <= 53'(t & LOW_BITS);
					else if (!have1_q) begin
						a_q <= t[31:5];
						have1_q <= 1'b1;
					end else res_q <= {a_q, t[31:6]};
				end
				default: ;
			endcase
		end
	end

	assign result = res_q;
	always_comb begin
		status.seed_last = (k_q == IDX_W'(STATE_WORDS-1));
		status.twist_last = (k_q == IDX_W'(STATE_WORDS-1));
		status.need_seed = (pos_q[ch_q] == POS_UNSEEDED);
		status.need_twist = (pos_q[ch_q] >= POS_FULL);
		status.second_word = have1_q;
		status.is_frac = (cmd_q == CMD_FRAC);
		status.is_seed = (cmd_q == CMD_SEED);
		status.is_none = (cmd_q == CMD_NONE);
	end
endmodule
`default_nettype wire

FILE: src/mmt_controller.sv
// Controller: sequences seeding, twisting and drawing; owns the handshake.
`default_nettype none
module mmt_controller (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	input  wire mmt_pkg::dp_status_t  status,
	output mmt_pkg::dp_cmd_t          cmd
);
	import mmt_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_DEC   = 11'b00000000010,
		S_SEED0 = 11'b00000000100,
		S_SEEDN = 11'b00000001000,
		S_TWR0  = 11'b00000010000,
		S_TWR1  = 11'b00000100000,
		S_TWR2  = 11'b00001000000,
		S_TWW   = 11'b00010000000,
		S_DRD   = 11'b00100000000,
		S_DWR   = 11'b01000000000,
		S_OUT   = 11'b10000000000
	} state_t;

	state_t state_q, state_d;
	logic dflt_q, dflt_d, mph_q, mph_d;

	always_comb begin
		state_d = state_q;
		dflt_d = dflt_q;
		mph_d = mph_q;
		cmd.op = DP_IDLE;
		cmd.use_default = dflt_q;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = DP_LOAD;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				priority if (status.is_none) state_d = S_IDLE;
				else if (status.is_seed) begin
					dflt_d = 1'b0;
					state_d = S_SEED0;
				end else if (status.need_seed) begin
					dflt_d = 1'b1;
					state_d = S_SEED0;
				end else if (status.need_twist) state_d = S_TWR0;
				else state_d = S_DRD;
			end
			S_SEED0: begin
				cmd.op = DP_SEED0;
				mph_d = 1'b0;
				state_d = S_SEEDN;
			end
			S_SEEDN: begin
				cmd.op = DP_SEEDN;
				mph_d = ~mph_q;
				if (mph_q && status.seed_last)
					state_d = status.is_seed ? S_IDLE : S_TWR0;
			end
			S_TWR0: begin
				cmd.op = DP_TW_RD;
				state_d = S_TWR1;
			end
			S_TWR1: begin
				cmd.op = DP_TW_RD;
				state_d = S_TWR2;
			end
			S_TWR2: begin
				cmd.op = DP_TW_RD2;
				state_d = S_TWW;
			end
			S_TWW: begin
				cmd.op = DP_TW_WR;
				state_d = status.twist_last ? S_DRD : S_TWR0;
			end
			S_DRD: begin
				cmd.op = DP_DRAW_RD;
				state_d = S_DWR;
			end
			S_DWR: begin
				cmd.op = DP_DRAW_WR;
				state_d = (status.is_frac && !status.second_word) ? S_DEC : S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			dflt_q <= 1'b0;
			mph_q <= 1'b0;
		end else begin
			state_q <= state_d;
			dflt_q <= dflt_d;
			mph_q <= mph_d;
		end
	end

`ifndef SYNTHESIS
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n) !(in_ready && out_valid))
		else $error("ready and valid together");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped");
`endif
endmodule
`default_nettype wire

FILE: bench/tb_multichannel_mersenne_twister_unit.sv
// Testbench: multichannel Mersenne Twister unit checked against a behavioral generator bank.
`timescale 1ns / 100ps
`default_nettype none
module tb_multichannel_mersenne_twister_unit;
	import mmt_pkg::*;

	typedef struct packed {
		cmd_t        cmd;
		logic [1:0]  ch;
		logic [31:0] seed;
	} txn_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  command;
	logic [1:0]  channel;
	logic [31:0] seed_value;
	logic        out_valid;
	logic        out_ready;
	logic [52:0] random_value;

	multichannel_mersenne_twister_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .channel(channel), .seed_value(seed_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.random_value(random_value)
	);

	always begin
		clk = 1'b1; #4;
		clk = 1'b0; #4;
	end

	// generator bank mirror
	logic [31:0] gen_words [CHANNELS][STATE_WORDS];
	int unsigned gen_pos [CHANNELS];

	txn_t        pending_txns [$];
	logic [52:0] expected_values [$];
	int          mismatches;
	int          gap_left;
	int          stall_left;
	logic        in_fire_q;
	longint      cycle_count;

	function automatic void seed_gen(input int c, input logic [31:0] s);
		logic [31:0] p;
		gen_words[c][0] = s;
		for (int i = 1; i < STATE_WORDS; i++) begin
			p = gen_words[c][i-1];
			gen_words[c][i] = INIT_MULT * (p ^ (p >> 30)) + 32'(i);
		end
		gen_pos[c] = STATE_WORDS;
	endfunction

	function automatic void twist_gen(input int c);
		logic [31:0] y;
		for (int k = 0; k < STATE_WORDS; k++) begin
			y = (gen_words[c][k] & HIGH_BIT) | (gen_words[c][(k+1) % STATE_WORDS] & LOW_BITS);
			gen_words[c][k] = gen_words[c][(k + TWIST_OFFSET) % STATE_WORDS] ^ (y >> 1)
				^ (y[0] ? TWIST_MATRIX : 32'd0);
		end
		gen_pos[c] = 0;
	endfunction

	function automatic logic [31:0] draw_tempered(input int c);
		logic [31:0] y;
		if (gen_pos[c] >= STATE_WORDS) begin
			if (gen_pos[c] != STATE_WORDS)
				seed_gen(c, DEFAULT_SEED);
			twist_gen(c);
		end
		y = gen_words[c][gen_pos[c]];
		gen_pos[c]++;
		y ^= y >> 11;
		y ^= (y << 7) & TEMPER_B;
		y ^= (y << 15) & TEMPER_C;
		y ^= y >> 18;
		return y;
	endfunction

	task automatic predict_txn(input txn_t t);
		int c;
		logic [31:0] a;
		logic [31:0] b;
		c = int'(t.ch) % CHANNELS;
		case (t.cmd)
			CMD_SEED: seed_gen(c, t.seed);
			CMD_INT: expected_values.push_back(53'(draw_tempered(c) & LOW_BITS));
			CMD_FRAC: begin
				a = draw_tempered(c) >> 5;
				b = draw_tempered(c) >> 6;
				expected_values.push_back({a[26:0], b[25:0]});
			end
			default: ;
		endcase
	endtask

	function automatic int pick_gap();
		if ($urandom_range(0, 3) == 0) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
		return $urandom_range(0, 3);
	endfunction

	// remember whether the input transaction went through at the last rising edge
	always @(posedge clk)
		in_fire_q <= in_valid && in_ready;

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && in_fire_q) begin
				in_valid <= 1'b0;
				gap_left <= pick_gap();
			end else if (!in_valid) begin
				if (gap_left > 0)
					gap_left <= gap_left - 1;
				else if (pending_txns.size() > 0) begin
					txn_t t;
					t = pending_txns.pop_front();
					command <= t.cmd;
					channel <= t.ch;
					seed_value <= t.seed;
					in_valid <= 1'b1;
				end
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_ready <= 1'b0;
			end else if ($urandom_range(0, 4) == 0) begin
				stall_left <= pick_gap();
				out_ready <= 1'b0;
			end else
				out_ready <= 1'b1;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				predict_txn('{cmd_t'(command), channel, seed_value});
			if (out_valid && out_ready) begin
				if (expected_values.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result %h", random_value);
				end else begin
					logic [52:0] e;
					e = expected_values.pop_front();
					if (e !== random_value) begin
						mismatches++;
						if (mismatches <= 10)
							$display("random_value mismatch: expected %h actual %h",
								e, random_value);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 64'd30000000) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic add_txn(input cmd_t c, input logic [1:0] ch, input logic [31:0] s);
		pending_txns.push_back('{c, ch, s});
	endtask

	initial begin
		int r;
		mismatches = 0;
		cycle_count = 0;
		gap_left = 0;
		stall_left = 0;
		in_fire_q = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		command = CMD_NONE;
		channel = 2'd0;
		seed_value = 32'd0;
		for (int c = 0; c < CHANNELS; c++)
			gen_pos[c] = STATE_WORDS + 1;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// unseeded draws, ignored command, seed extremes
		add_txn(CMD_INT, 2'd0, 32'hffffffff);
		add_txn(CMD_FRAC, 2'd1, 32'd0);
		add_txn(CMD_NONE, 2'd2, 32'hffffffff);
		add_txn(CMD_INT, 2'd3, 32'h0);
		add_txn(CMD_SEED, 2'd2, 32'd0);
		add_txn(CMD_INT, 2'd2, 32'd0);
		add_txn(CMD_SEED, 2'd3, 32'hffffffff);
		add_txn(CMD_FRAC, 2'd3, 32'd0);
		add_txn(CMD_SEED, 2'd0, 32'h5555aaaa);
		add_txn(CMD_NONE, 2'd0, 32'h0);
		add_txn(CMD_INT, 2'd0, 32'h0);
		add_txn(CMD_SEED, 2'd1, 32'haaaa5555);
		add_txn(CMD_FRAC, 2'd1, 32'hffffffff);
		add_txn(CMD_INT, 2'd1, 32'h0);
		// random part; draw-heavy so channels wrap and twist
		for (int i = 0; i < 400; i++) begin
			r = $urandom_range(0, 99);
			if (r < 5)
				add_txn(CMD_SEED, 2'($urandom), $urandom);
			else if (r < 8)
				add_txn(CMD_NONE, 2'($urandom), $urandom);
			else if (r < 55)
				add_txn(CMD_INT, 2'($urandom), $urandom);
			else
				add_txn(CMD_FRAC, 2'($urandom), $urandom);
		end
		// long run on one channel to pass the state end
		for (int i = 0; i < 336; i++)
			add_txn(CMD_FRAC, 2'd2, $urandom);

		wait (pending_txns.size() == 0 && !in_valid);
		wait (expected_values.size() == 0);
		repeat (12000) @(posedge clk);
		if (mismatches == 0 && expected_values.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
`default_nettype wire
